// ===== rtl/olee_pkg.sv =====
`timescale 1ns / 1ps
package olee_pkg;

  localparam logic [2:0] REQ_APPEND     = 3'd0;
  localparam logic [2:0] REQ_INSERT     = 3'd1;
  localparam logic [2:0] REQ_REMOVE_AT  = 3'd2;
  localparam logic [2:0] REQ_REMOVE_VAL = 3'd3;
  localparam logic [2:0] REQ_DEDUPE     = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE_AT,
    OP_REMOVE_VAL,
    OP_DEDUPE,
    OP_SHOW
  } op_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
    logic               list_empty;
    logic               last;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  position;
    logic [31:0] item_value;
  } cmd_t;

endpackage

// ===== rtl/olee_front.sv =====
`timescale 1ns / 1ps
module olee_front (
  input  olee_pkg::in_t  in_data,
  output olee_pkg::cmd_t cmd
);
  import olee_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_data.req_type)
      REQ_APPEND:     op = OP_APPEND;
      REQ_INSERT:     op = OP_INSERT;
      REQ_REMOVE_AT:  op = OP_REMOVE_AT;
      REQ_REMOVE_VAL: op = OP_REMOVE_VAL;
      REQ_DEDUPE:     op = OP_DEDUPE;
      default:        op = OP_SHOW;
    endcase
  end

  assign cmd.op         = op;
  assign cmd.position   = in_data.position;
  assign cmd.item_value = in_data.item_value;

endmodule

// ===== rtl/olee_queue.sv =====
`timescale 1ns / 1ps
module olee_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  olee_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output olee_pkg::cmd_t pop_data
);
  import olee_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

endmodule

// ===== rtl/olee_back.sv =====
`timescale 1ns / 1ps
module olee_back #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  olee_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output olee_pkg::out_t out_data
);
  import olee_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_INS    = 9'b000000010,
    S_INS_WR = 9'b000000100,
    S_C_RD   = 9'b000001000,
    S_C_CHK  = 9'b000010000,
    S_D_RD   = 9'b000100000,
    S_D_CMP  = 9'b001000000,
    S_E_RD   = 9'b010000000,
    S_E_OUT  = 9'b100000000
  } state_t;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  op_t         op_r, op_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] x_r, x_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        ov_r, ov_nxt;
  out_t        od_r, od_nxt;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  logic [CW-1:0] im1, ip1;
  logic          free, drop;

  assign free      = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign im1       = i_r - CW'(1);
  assign ip1       = i_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    wr_nxt    = wr_r;
    k_nxt     = k_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    x_nxt     = x_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    q_pop     = 1'b0;
    drop      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_nonempty) begin
          q_pop   = 1'b1;
          op_nxt  = q_data.op;
          pos_nxt = q_data.position;
          val_nxt = q_data.item_value;
          st_nxt  = ST_OK;
          i_nxt   = '0;
          wr_nxt  = '0;
          state_nxt = S_E_RD;
          unique case (q_data.op)
            OP_APPEND: begin
              if (7'(cnt_r) == 7'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[AW-1:0];
                wdata   = q_data.item_value;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_INSERT: begin
              if (7'(cnt_r) == 7'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else if (7'(q_data.position) > 7'(cnt_r)) begin
                st_nxt = ST_BADPOS;
              end else begin
                i_nxt     = cnt_r;
                state_nxt = S_INS;
              end
            end
            OP_REMOVE_AT: begin
              if (7'(q_data.position) >= 7'(cnt_r)) st_nxt = ST_BADPOS;
              else state_nxt = S_C_RD;
            end
            OP_REMOVE_VAL, OP_DEDUPE: state_nxt = S_C_RD;
            default: state_nxt = S_E_RD;
          endcase
        end
      end
      S_INS: begin
        if (7'(i_r) == 7'(pos_r)) begin
          we        = 1'b1;
          waddr     = i_r[AW-1:0];
          wdata     = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          i_nxt     = '0;
          state_nxt = S_E_RD;
        end else begin
          re        = 1'b1;
          raddr     = im1[AW-1:0];
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we        = 1'b1;
        waddr     = i_r[AW-1:0];
        wdata     = rdata_r;
        i_nxt     = im1;
        state_nxt = S_INS;
      end
      S_C_RD: begin
        if (i_r == cnt_r) begin
          cnt_nxt   = wr_r;
          i_nxt     = '0;
          state_nxt = S_E_RD;
        end else begin
          re        = 1'b1;
          raddr     = i_r[AW-1:0];
          state_nxt = S_C_CHK;
        end
      end
      S_C_CHK: begin
        x_nxt = rdata_r;
        if (op_r == OP_DEDUPE) begin
          k_nxt     = '0;
          state_nxt = S_D_RD;
        end else begin
          if (op_r == OP_REMOVE_AT) drop = (7'(i_r) == 7'(pos_r));
          else drop = (rdata_r == val_r);
          if (!drop) begin
            we     = 1'b1;
            waddr  = wr_r[AW-1:0];
            wdata  = rdata_r;
            wr_nxt = wr_r + CW'(1);
          end
          i_nxt     = ip1;
          state_nxt = S_C_RD;
        end
      end
      S_D_RD: begin
        if (k_r == wr_r) begin
          we        = 1'b1;
          waddr     = wr_r[AW-1:0];
          wdata     = x_r;
          wr_nxt    = wr_r + CW'(1);
          i_nxt     = ip1;
          state_nxt = S_C_RD;
        end else begin
          re        = 1'b1;
          raddr     = k_r[AW-1:0];
          state_nxt = S_D_CMP;
        end
      end
      S_D_CMP: begin
        if (rdata_r == x_r) begin
          i_nxt     = ip1;
          state_nxt = S_C_RD;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_D_RD;
        end
      end
      S_E_RD: begin
        re        = (cnt_r != '0);
        raddr     = i_r[AW-1:0];
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (free) begin
          ov_nxt             = 1'b1;
          od_nxt.status      = st_r;
          od_nxt.entry_count = 7'(cnt_r);
          od_nxt.entry_index = 6'(i_r);
          od_nxt.list_empty  = (cnt_r == '0);
          od_nxt.entry_value = (cnt_r == '0) ? '0 : rdata_r;
          od_nxt.last        = (cnt_r == '0) || (ip1 == cnt_r);
          if (od_nxt.last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = ip1;
            state_nxt = S_E_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    wr_r  <= wr_nxt;
    k_r   <= k_nxt;
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    x_r   <= x_nxt;
    st_r  <= st_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/ordered_list_edit_engine_unit.sv =====
// A request is taken from the queue; insert moves each element from the position on up one
// slot (read, then write), remove at a position and remove value read every entry and write
// back the kept ones, dedupe compares every entry against the entries kept so far; then each
// entry is read and emitted as a result (one result if empty). One single-port list memory
// does it all; one request at a time in the back end; a 2-entry queue takes input until full.
// Reset (rst_n low, synchronous) empties the list and queue; the memory is not cleared.
`timescale 1ns / 1ps
module ordered_list_edit_engine_unit #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  olee_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output olee_pkg::out_t  out_data
);
  import olee_pkg::*;

  cmd_t cmd, q_data;
  logic q_full, q_nonempty, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  olee_front u_front (
    .in_data (in_data),
    .cmd     (cmd)
  );

  olee_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_data)
  );

  olee_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/olee_checker.sv =====
`timescale 1ns / 1ps
module olee_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input olee_pkg::out_t out_data
);
  import olee_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |-> out_data.last && out_data.entry_count == 7'd0)
    else $error("empty result malformed");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.list_empty |-> 7'(out_data.entry_index) < out_data.entry_count)
    else $error("index beyond count");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.list_empty && out_data.last
      |-> 7'(out_data.entry_index) + 7'd1 == out_data.entry_count)
    else $error("last marker misplaced");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_FULL ||
                  out_data.status == ST_BADPOS)
    else $error("bad status code");

endmodule

bind ordered_list_edit_engine_unit olee_checker u_olee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_ordered_list_edit_engine_unit.sv =====
`timescale 1ns / 1ps
module tb_ordered_list_edit_engine_unit;
  import olee_pkg::*;

  localparam int DEPTH = 32;

  class list_scoreboard;
    logic signed [31:0] entries[DEPTH];
    int                 n_entries;
    out_t               pending[$];

    function void clear();
      n_entries = 0;
      pending.delete();
    endfunction

    function void drop_at(int idx);
      for (int i = idx; i + 1 < n_entries; i++) entries[i] = entries[i + 1];
      n_entries--;
    endfunction

    function void note_request(in_t req);
      logic [1:0] st;
      int         wr;
      int         j;
      out_t       r;
      st = ST_OK;
      case (req.req_type)
        REQ_APPEND: begin
          if (n_entries >= DEPTH) st = ST_FULL;
          else begin
            entries[n_entries] = req.item_value;
            n_entries++;
          end
        end
        REQ_INSERT: begin
          if (n_entries >= DEPTH) st = ST_FULL;
          else if (req.position > n_entries) st = ST_BADPOS;
          else begin
            for (int i = n_entries; i > req.position; i--) entries[i] = entries[i - 1];
            entries[req.position] = req.item_value;
            n_entries++;
          end
        end
        REQ_REMOVE_AT: begin
          if (req.position >= n_entries) st = ST_BADPOS;
          else drop_at(req.position);
        end
        REQ_REMOVE_VAL: begin
          wr = 0;
          for (int i = 0; i < n_entries; i++)
            if (entries[i] != req.item_value) begin
              entries[wr] = entries[i];
              wr++;
            end
          n_entries = wr;
        end
        REQ_DEDUPE: begin
          for (int i = 0; i < n_entries; i++) begin
            j = i + 1;
            while (j < n_entries) begin
              if (entries[j] == entries[i]) drop_at(j);
              else j++;
            end
          end
        end
        default: ;
      endcase
      if (n_entries == 0) begin
        r = '0;
        r.status = st;
        r.list_empty = 1'b1;
        r.last = 1'b1;
        pending.push_back(r);
      end else begin
        for (int i = 0; i < n_entries; i++) begin
          r = '0;
          r.status = st;
          r.entry_count = 7'(n_entries);
          r.entry_index = 6'(i);
          r.entry_value = entries[i];
          r.last = (i + 1 == n_entries);
          pending.push_back(r);
        end
      end
    endfunction

    function bit check_result(out_t got, output string msg);
      out_t w;
      msg = "";
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected transfer %p", got);
        return 0;
      end
      w = pending.pop_front();
      if (got.status != w.status) msg = {msg, $sformatf(" status %0d/%0d", got.status, w.status)};
      if (got.list_empty != w.list_empty)
        msg = {msg, $sformatf(" empty %0d/%0d", got.list_empty, w.list_empty)};
      if (got.last != w.last) msg = {msg, $sformatf(" last %0d/%0d", got.last, w.last)};
      if (!w.list_empty) begin
        if (got.entry_count != w.entry_count)
          msg = {msg, $sformatf(" count %0d/%0d", got.entry_count, w.entry_count)};
        if (got.entry_index != w.entry_index)
          msg = {msg, $sformatf(" index %0d/%0d", got.entry_index, w.entry_index)};
        if (got.entry_value != w.entry_value)
          msg = {msg, $sformatf(" value %0d/%0d", got.entry_value, w.entry_value)};
      end
      return msg == "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  list_scoreboard sb = new();
  int  fail_count = 0;
  bit  hold_off_req = 0;
  int  rand_recent[$];

  ordered_list_edit_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send(logic [2:0] rt, logic [5:0] pos, logic signed [31:0] v, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= {rt, pos, v};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request({rt, pos, v});
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && rand_recent.size() > 0)
      return rand_recent[$urandom_range(0, rand_recent.size() - 1)];
    if (r < 7) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && sb.n_entries > 0) return 6'($urandom_range(0, sb.n_entries));
    return 6'($urandom_range(0, 63));
  endfunction

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall)
      if (!sb.check_result(out_data, msg)) report(msg);
  end

  initial begin
    int g;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off_req = 0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        g = gap_len();
        out_stall <= (g != 0);
        if (g != 0) begin
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [2:0]         rt;
    logic signed [31:0] v;
    int                 r;
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(OP_SHOW, 0, 0);
    send(REQ_REMOVE_AT, 0, 0);
    send(REQ_INSERT, 1, 5);
    send(REQ_INSERT, 0, 32'sh7fffffff);
    send(REQ_APPEND, 0, 32'sh80000000);
    send(REQ_APPEND, 0, -1);
    send(REQ_APPEND, 0, 32'sh7fffffff);
    send(REQ_INSERT, 63, 0);
    send(REQ_INSERT, 4, 2);
    send(REQ_REMOVE_AT, 63, 0);
    send(REQ_DEDUPE, 0, 0);
    send(REQ_REMOVE_VAL, 0, 99);
    send(REQ_REMOVE_VAL, 0, -1);
    send(3'd6, 0, 0);
    send(3'd7, 63, 32'hffffffff);
    for (int i = 0; i < DEPTH; i++) send(REQ_APPEND, 0, i % 3, 0);
    send(REQ_APPEND, 0, 1);
    send(REQ_INSERT, 63, 1);
    send(REQ_INSERT, 0, 1);
    drain();
    send(REQ_DEDUPE, 0, 0);
    send(REQ_REMOVE_AT, 2, 0);
    send(REQ_REMOVE_AT, 0, 0);
    send(REQ_REMOVE_AT, 0, 0);

    hold_off_req = 1;
    for (int i = 0; i < 8; i++) send(REQ_APPEND, 0, $urandom, 0);
    drain();

    for (int k = 0; k < 350; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) rt = REQ_APPEND;
      else if (r < 55) rt = REQ_INSERT;
      else if (r < 72) rt = REQ_REMOVE_AT;
      else if (r < 82) rt = REQ_REMOVE_VAL;
      else if (r < 90) rt = REQ_DEDUPE;
      else rt = 3'($urandom_range(5, 7));
      v = pick_value();
      rand_recent.push_back(v);
      if (rand_recent.size() > 8) void'(rand_recent.pop_front());
      send(rt, pick_pos(), v);
      if (k == 175) drain();
      if (sb.n_entries > 28 && $urandom_range(0, 3) == 0) send(REQ_REMOVE_VAL, 0, v);
    end
    drain();
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("tb_ordered_list_edit_engine_unit: clean");
    end else begin
      $display("tb_ordered_list_edit_engine_unit: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_ordered_list_edit_engine_unit: errors");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/olee_pkg.sv
rtl/olee_front.sv
rtl/olee_queue.sv
rtl/olee_back.sv
rtl/ordered_list_edit_engine_unit.sv
rtl/olee_checker.sv
tb/tb_ordered_list_edit_engine_unit.sv
